### hdl/rcuc_pkg.sv
// ----------------------------------------------------------------------------
// rcuc_pkg
// shared types and constants for the rc channel unpack and range check block
// ----------------------------------------------------------------------------
package rcuc_pkg;

   localparam int NUM_CH   = 8;
   localparam int RAW_W    = 12;
   localparam int COUNT_W  = 16;

   // accepted window on the scaled channel value, inclusive
   localparam logic [RAW_W-1:0] CH_MIN = 12'd800;
   localparam logic [RAW_W-1:0] CH_MAX = 12'd2200;

   // floor(n / 3) = (n * 21846) >> 16 for every n below 2**13
   localparam int               SCALE_SHIFT = 16;
   localparam logic [14:0]      SCALE_RECIP = 15'd21846;

   typedef logic [NUM_CH-1:0][RAW_W-1:0] chan_array_type;

   typedef struct packed {
      logic [7:0] lo_ch0;
      logic [7:0] lo_ch1;
      logic [7:0] lo_ch2;
      logic [7:0] lo_ch3;
      logic [7:0] hi_ch01;
      logic [7:0] hi_ch23;
      logic [7:0] lo_ch4;
      logic [7:0] lo_ch5;
      logic [7:0] lo_ch6;
      logic [7:0] lo_ch7;
      logic [7:0] hi_ch45;
      logic [7:0] hi_ch67;
   } req_type;

   typedef struct packed {
      logic [RAW_W-1:0]   out_ch0;
      logic [RAW_W-1:0]   out_ch1;
      logic [RAW_W-1:0]   out_ch2;
      logic [RAW_W-1:0]   out_ch3;
      logic [RAW_W-1:0]   out_ch4;
      logic [RAW_W-1:0]   out_ch5;
      logic [RAW_W-1:0]   out_ch6;
      logic [RAW_W-1:0]   out_ch7;
      logic               accepted;
      logic [COUNT_W-1:0] reject_count;
   } rsp_type;

endpackage

### hdl/rcuc_unpack.sv
// ----------------------------------------------------------------------------
// rcuc_unpack
// joins the low bytes with the shared high nibbles into eight raw channels
// ----------------------------------------------------------------------------
module rcuc_unpack (
   input  rcuc_pkg::req_type        frame,
   output rcuc_pkg::chan_array_type raw
);
   import rcuc_pkg::*;

   // even channels take the low nibble, odd channels the high nibble
   assign raw[0] = {frame.hi_ch01[3:0], frame.lo_ch0};
   assign raw[1] = {frame.hi_ch01[7:4], frame.lo_ch1};
   assign raw[2] = {frame.hi_ch23[3:0], frame.lo_ch2};
   assign raw[3] = {frame.hi_ch23[7:4], frame.lo_ch3};
   assign raw[4] = {frame.hi_ch45[3:0], frame.lo_ch4};
   assign raw[5] = {frame.hi_ch45[7:4], frame.lo_ch5};
   assign raw[6] = {frame.hi_ch67[3:0], frame.lo_ch6};
   assign raw[7] = {frame.hi_ch67[7:4], frame.lo_ch7};

endmodule

### hdl/rcuc_chan_scale.sv
// ----------------------------------------------------------------------------
// rcuc_chan_scale
// scales one raw channel to floor(2x/3) and checks it against the window
// ----------------------------------------------------------------------------
module rcuc_chan_scale (
   input  logic [rcuc_pkg::RAW_W-1:0] raw,
   output logic [rcuc_pkg::RAW_W-1:0] scaled,
   output logic                       in_range
);
   import rcuc_pkg::*;

   logic [RAW_W:0]   doubled;
   logic [27:0]      prod;

   assign doubled  = {raw, 1'b0};
   // constant reciprocal multiply, exact for all 13-bit dividends
   assign prod     = {15'd0, doubled} * {13'd0, SCALE_RECIP};
   assign scaled   = prod[SCALE_SHIFT +: RAW_W];
   assign in_range = (scaled >= CH_MIN) && (scaled <= CH_MAX);

endmodule

### hdl/rc_channel_unpack_check_core.sv
// ----------------------------------------------------------------------------
// rc_channel_unpack_check_core
// radio frame channel unpacker with range check and reject counter
// ----------------------------------------------------------------------------
// Takes the twelve channel bytes of one radio frame per item and returns one
// result item per frame. An item is registered on entry, unpacked into eight
// 12-bit raw channels, scaled to floor(2x/3) by a constant reciprocal
// multiply and range checked against 800..2200, then written to the result
// register, whose valid flag drives rsp_valid. Throughput is one item per
// cycle, set by the single pass of unpack, scale and compare logic between
// the two registers; a stalled result holds the input register and in turn
// stalls the input. The result register doubles as the block state: its
// channel fields are the held values (zero after reset) and its count field
// is the 16-bit wrapping reject counter. A frame with any channel out of
// range leaves the held values alone, bumps the counter and reports
// accepted low.
// ----------------------------------------------------------------------------
module rc_channel_unpack_check_core (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  rcuc_pkg::req_type req_item,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rcuc_pkg::rsp_type rsp_item
);
   import rcuc_pkg::*;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff,  in_item_in;

   // result register, also the held channel values and reject counter
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff,       rsp_in;

   // pipeline control
   logic req_take;
   logic load;

   // datapath
   chan_array_type     raw;
   chan_array_type     scaled;
   logic [NUM_CH-1:0]  in_range;
   logic               frame_ok;

   // result register frees up when empty or being taken this cycle
   assign load      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !load;
   assign req_take  = req_valid && !req_stall;

   // unpack the shared high nibbles
   rcuc_unpack u_unpack (
      .frame (in_item_ff),
      .raw   (raw)
   );

   // one scaler and window check per channel
   for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
      rcuc_chan_scale u_scale (
         .raw      (raw[g]),
         .scaled   (scaled[g]),
         .in_range (in_range[g])
      );
   end

   assign frame_ok = &in_range;

   // input register next value
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // result and state next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in    = 1'b1;
         rsp_in.accepted = frame_ok;
         if (frame_ok) begin
            // replace every held channel
            rsp_in.out_ch0 = scaled[0];
            rsp_in.out_ch1 = scaled[1];
            rsp_in.out_ch2 = scaled[2];
            rsp_in.out_ch3 = scaled[3];
            rsp_in.out_ch4 = scaled[4];
            rsp_in.out_ch5 = scaled[5];
            rsp_in.out_ch6 = scaled[6];
            rsp_in.out_ch7 = scaled[7];
         end else begin
            // held values stay, counter wraps at 16 bits
            rsp_in.reject_count = COUNT_W'(rsp_ff.reject_count + 1'b1);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a rejected frame bumps the counter by exactly one
   a_reject_count: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_ff.accepted ||
               rsp_ff.reject_count == COUNT_W'($past(rsp_ff.reject_count) + 1'b1))
      else $error("reject counter did not advance on rejected frame");

   // a rejected frame leaves every held channel unchanged
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_ff.accepted ||
               (rsp_ff.out_ch0 == $past(rsp_ff.out_ch0) &&
                rsp_ff.out_ch1 == $past(rsp_ff.out_ch1) &&
                rsp_ff.out_ch2 == $past(rsp_ff.out_ch2) &&
                rsp_ff.out_ch3 == $past(rsp_ff.out_ch3) &&
                rsp_ff.out_ch4 == $past(rsp_ff.out_ch4) &&
                rsp_ff.out_ch5 == $past(rsp_ff.out_ch5) &&
                rsp_ff.out_ch6 == $past(rsp_ff.out_ch6) &&
                rsp_ff.out_ch7 == $past(rsp_ff.out_ch7)))
      else $error("held channels changed on rejected frame");

   // an accepted frame keeps the counter and holds in-window values on channels 0 and 7
   a_accept_window: assert property (@(posedge clock) disable iff (reset)
      load |=> !rsp_ff.accepted ||
               (rsp_ff.reject_count == $past(rsp_ff.reject_count) &&
                rsp_ff.out_ch0 >= CH_MIN && rsp_ff.out_ch0 <= CH_MAX &&
                rsp_ff.out_ch7 >= CH_MIN && rsp_ff.out_ch7 <= CH_MAX))
      else $error("accepted frame with counter change or out of window value");

   // input side only stalls while an item waits in the input register behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked item");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the rc channel unpack and range check core
// ----------------------------------------------------------------------------
// Frames go in on the req channel, results come back on the rsp channel. A
// scoreboard class keeps its own copy of the held channel values and the
// reject counter. It builds the expected result for every incoming frame and
// compares each returned result field by field, in order. Stimulus starts with
// directed frames: all-zero and all-ones bytes, the window edges and each
// channel pushed just outside the window. Next comes a short back-to-back run
// of rejected frames, a burst against a stalled receiver, and a random mix of
// mostly in-window frames with boundary, out-of-window and raw noise frames.
// Both sides idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcuc_pkg::*;

   // predicts one result per frame and checks results in arrival order
   class frame_scoreboard;
      chan_array_type     held;
      logic [COUNT_W-1:0] rejects;
      rsp_type            expected_q[$];
      int unsigned        fail_count;

      function new();
         held       = '0;
         rejects    = '0;
         fail_count = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_frame(req_type f);
         chan_array_type raw;
         chan_array_type scaled;
         int unsigned    wide;
         logic           in_window;
         rsp_type        r;
         raw[0] = {f.hi_ch01[3:0], f.lo_ch0};
         raw[1] = {f.hi_ch01[7:4], f.lo_ch1};
         raw[2] = {f.hi_ch23[3:0], f.lo_ch2};
         raw[3] = {f.hi_ch23[7:4], f.lo_ch3};
         raw[4] = {f.hi_ch45[3:0], f.lo_ch4};
         raw[5] = {f.hi_ch45[7:4], f.lo_ch5};
         raw[6] = {f.hi_ch67[3:0], f.lo_ch6};
         raw[7] = {f.hi_ch67[7:4], f.lo_ch7};
         in_window = 1'b1;
         for (int i = 0; i < NUM_CH; i++) begin
            wide      = 32'(raw[i]);
            scaled[i] = RAW_W'(wide * 2 / 3);
            if (scaled[i] < CH_MIN || scaled[i] > CH_MAX) in_window = 1'b0;
         end
         if (in_window) held = scaled;
         else rejects = rejects + 1'b1;
         r.out_ch0      = held[0];
         r.out_ch1      = held[1];
         r.out_ch2      = held[2];
         r.out_ch3      = held[3];
         r.out_ch4      = held[4];
         r.out_ch5      = held[5];
         r.out_ch6      = held[6];
         r.out_ch7      = held[7];
         r.accepted     = in_window;
         r.reject_count = rejects;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got === want) return;
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            fail_count++;
            $display("%0t ns: result with nothing expected, expected none, got %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_ch0", 16'(want.out_ch0), 16'(got.out_ch0));
         compare_field("out_ch1", 16'(want.out_ch1), 16'(got.out_ch1));
         compare_field("out_ch2", 16'(want.out_ch2), 16'(got.out_ch2));
         compare_field("out_ch3", 16'(want.out_ch3), 16'(got.out_ch3));
         compare_field("out_ch4", 16'(want.out_ch4), 16'(got.out_ch4));
         compare_field("out_ch5", 16'(want.out_ch5), 16'(got.out_ch5));
         compare_field("out_ch6", 16'(want.out_ch6), 16'(got.out_ch6));
         compare_field("out_ch7", 16'(want.out_ch7), 16'(got.out_ch7));
         compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
         compare_field("reject_count", want.reject_count, got.reject_count);
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   // quiet: neither side idles; hold_rsp: receiver takes one long hold-off
   bit quiet    = 1'b0;
   bit hold_rsp = 1'b0;

   frame_scoreboard sb;

   always #6 clock = ~clock;

   rc_channel_unpack_check_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // spread eight 12-bit raw channels over the twelve frame bytes
   function automatic req_type pack_frame(input chan_array_type c);
      req_type f;
      f.lo_ch0  = c[0][7:0];
      f.lo_ch1  = c[1][7:0];
      f.lo_ch2  = c[2][7:0];
      f.lo_ch3  = c[3][7:0];
      f.hi_ch01 = {c[1][11:8], c[0][11:8]};
      f.hi_ch23 = {c[3][11:8], c[2][11:8]};
      f.lo_ch4  = c[4][7:0];
      f.lo_ch5  = c[5][7:0];
      f.lo_ch6  = c[6][7:0];
      f.lo_ch7  = c[7][7:0];
      f.hi_ch45 = {c[5][11:8], c[4][11:8]};
      f.hi_ch67 = {c[7][11:8], c[6][11:8]};
      return f;
   endfunction

   // raw 1200..3301 scales into 800..2200
   function automatic chan_array_type in_window_raws();
      chan_array_type c;
      for (int i = 0; i < NUM_CH; i++) c[i] = 12'($urandom_range(1200, 3301));
      return c;
   endfunction

   function automatic logic [RAW_W-1:0] outside_raw();
      if ($urandom_range(0, 1)) return 12'($urandom_range(0, 1199));
      return 12'($urandom_range(3302, 4095));
   endfunction

   // one channel forced outside the window, the rest inside
   function automatic req_type reject_frame();
      chan_array_type c;
      c = in_window_raws();
      c[$urandom_range(0, 7)] = outside_raw();
      return pack_frame(c);
   endfunction

   // mostly well-formed frames, then window edges, rejects and raw noise
   function automatic req_type random_frame();
      chan_array_type c;
      int unsigned    pick;
      int unsigned    victim;
      pick   = $urandom_range(0, 99);
      victim = $urandom_range(0, 7);
      c      = in_window_raws();
      if (pick < 60) return pack_frame(c);
      if (pick < 78) begin
         // raws that scale to 798, 799, 800, 800 or 2200, 2200, 2201, 2202
         if ($urandom_range(0, 1)) c[victim] = 12'(1198 + $urandom_range(0, 3));
         else c[victim] = 12'(3300 + $urandom_range(0, 3));
         return pack_frame(c);
      end
      if (pick < 90) begin
         c[victim] = outside_raw();
         return pack_frame(c);
      end
      return req_type'({$urandom, $urandom, $urandom});
   endfunction

   // offer one frame after a random gap and hold it until taken
   task automatic send_frame(input req_type f);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= f;
      do @(posedge clock); while (!(req_valid && req_stall === 1'b0));
   endtask

   // stop offering and wait until every expected result is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // both handshakes are seen here on the rising edge, frames before results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) sb.note_frame(req_item);
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_item);
      end
   end

   // receiver: random stall before each result, one long hold when asked
   initial begin : rsp_side
      int unsigned wait_cycles;
      forever begin
         if (hold_rsp) begin
            wait_cycles = 200;
            hold_rsp    = 1'b0;
         end else if (quiet) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 12);
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   initial begin : stimulus
      chan_array_type c;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all bytes low, then all high: both rejected, outputs still zero
      send_frame('0);
      send_frame('1);

      // lower and upper window edges, then a spread of in-window values
      for (int i = 0; i < NUM_CH; i++) c[i] = 12'd1200;
      send_frame(pack_frame(c));
      for (int i = 0; i < NUM_CH; i++) c[i] = 12'd3301;
      send_frame(pack_frame(c));
      for (int i = 0; i < NUM_CH; i++) c[i] = 12'(1500 + 97 * i);
      send_frame(pack_frame(c));

      // each channel alone just below, then just above the window
      for (int v = 0; v < NUM_CH; v++) begin
         for (int i = 0; i < NUM_CH; i++) c[i] = 12'd2000;
         c[v] = 12'd1199;
         send_frame(pack_frame(c));
      end
      for (int v = 0; v < NUM_CH; v++) begin
         for (int i = 0; i < NUM_CH; i++) c[i] = 12'd2400;
         c[v] = 12'd3302;
         send_frame(pack_frame(c));
      end

      // values that land on the edges (1201 rounds down to 800), alternating low and high
      for (int i = 0; i < NUM_CH; i++) c[i] = i[0] ? 12'd3300 : 12'd1201;
      send_frame(pack_frame(c));

      // a back-to-back run of rejects
      quiet = 1'b1;
      repeat (20) send_frame(reject_frame());
      drain();

      // receiver holds off while frames keep coming, so the core backs up
      hold_rsp = 1'b1;
      repeat (60) send_frame(random_frame());
      quiet = 1'b0;

      // random mix, with quiet stretches and one full drain midway
      for (int k = 0; k < 1350; k++) begin
         if (k % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (k == 700) drain();
         send_frame(random_frame());
      end
      quiet = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
